// ----- hw/rtl/psla4_pkg.sv -----
// Package for the averaged PID speed loop.
// Holds the sample type, field widths, register indexes and fixed constants.
// No dependencies.
package psla4_pkg;

	localparam int unsigned TARGET_W = 8;
	localparam int unsigned MEAS_W   = 16;
	localparam int unsigned SPEED_W  = 7;
	localparam int unsigned GAIN_W   = 16;
	localparam int unsigned ERR_W    = 12;
	localparam int unsigned DERIV_W  = 13;
	localparam int unsigned DUTY_W   = 7;
	localparam int unsigned CFG_AW   = 2;
	localparam int unsigned HIST_D   = 3;

	localparam logic [SPEED_W-1:0] SPEED_CLAMP = 7'd100;
	localparam logic [DUTY_W-1:0]  DUTY_MAX    = 7'd100;
	localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd655;

	localparam logic [CFG_AW-1:0] CFG_KP = 2'd0;
	localparam logic [CFG_AW-1:0] CFG_KI = 2'd1;
	localparam logic [CFG_AW-1:0] CFG_KD = 2'd2;

	typedef struct packed {
		logic [TARGET_W-1:0] target;
		logic [SPEED_W-1:0]  meas;
		logic                dir;
	} smp_t;

endpackage

// ----- hw/rtl/psla4_front.sv -----
// Input register stage: clamps the measured speed and registers the sample.
// Depends on psla4_pkg.
module psla4_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [psla4_pkg::TARGET_W-1:0]      cmd_speed,
	input  logic [psla4_pkg::MEAS_W-1:0]        measured_speed,
	input  logic                                direction,
	output logic                                out_valid,
	input  logic                                out_ready,
	output psla4_pkg::smp_t                     out_smp
);

	logic                             valid_s1_q;
	psla4_pkg::smp_t                  smp_s1;
	logic [psla4_pkg::SPEED_W-1:0]    meas_clamp;

	assign in_ready = !valid_s1_q || out_ready;
	assign meas_clamp = (measured_speed > 16'd100) ? psla4_pkg::SPEED_CLAMP
		: measured_speed[psla4_pkg::SPEED_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
		end else if (in_ready) begin
			valid_s1_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			smp_s1.target <= cmd_speed;
			smp_s1.meas   <= meas_clamp;
			smp_s1.dir    <= direction;
		end
	end

	assign out_valid = valid_s1_q;
	assign out_smp   = smp_s1;

endmodule

// ----- hw/rtl/psla4_err.sv -----
// Error stage: moving-average error, integral and derivative, loop state.
// Depends on psla4_pkg.
module psla4_err #(
	parameter int unsigned INTEGRAL_WIDTH = 24
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  psla4_pkg::smp_t                        in_smp,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [psla4_pkg::ERR_W-1:0]     err,
	output logic signed [psla4_pkg::DERIV_W-1:0]   deriv,
	output logic [INTEGRAL_WIDTH-1:0]              integ,
	output logic                                   dir
);

	localparam int unsigned IW = INTEGRAL_WIDTH;

	logic                                  valid_s2_q;
	logic signed [psla4_pkg::ERR_W-1:0]    err_s2;
	logic signed [psla4_pkg::DERIV_W-1:0]  deriv_s2;
	logic [IW-1:0]                         integ_s2;
	logic                                  dir_s2;

	logic [psla4_pkg::SPEED_W-1:0]         hist_q [psla4_pkg::HIST_D];
	logic signed [psla4_pkg::ERR_W-1:0]    prev_err_q;
	logic [IW-1:0]                         integ_q;

	logic                                  ld;
	logic [8:0]                            sum_c;
	logic signed [psla4_pkg::ERR_W-1:0]    err_c;
	logic [IW-1:0]                         base_c;
	logic signed [IW+1:0]                  isum_c;
	logic [IW-1:0]                         integ_c;
	logic signed [psla4_pkg::DERIV_W-1:0]  deriv_c;

	assign in_ready = !valid_s2_q || out_ready;
	assign ld = in_valid && in_ready;

	always_comb begin
		sum_c = {2'b00, in_smp.meas} + {2'b00, hist_q[0]} + {2'b00, hist_q[1]}
			+ {2'b00, hist_q[2]};
		err_c = $signed({2'b00, in_smp.target, 2'b00}) - $signed({3'b000, sum_c});
		base_c = (in_smp.target == '0) ? '0 : integ_q;
		isum_c = $signed({2'b00, base_c})
			+ $signed({{(IW + 2 - psla4_pkg::ERR_W){err_c[psla4_pkg::ERR_W-1]}}, err_c});
		if (isum_c[IW+1]) begin
			integ_c = '0;
		end else if (isum_c[IW]) begin
			integ_c = '1;
		end else begin
			integ_c = isum_c[IW-1:0];
		end
		deriv_c = $signed({err_c[psla4_pkg::ERR_W-1], err_c})
			- $signed({prev_err_q[psla4_pkg::ERR_W-1], prev_err_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2_q <= 1'b0;
			hist_q[0]  <= '0;
			hist_q[1]  <= '0;
			hist_q[2]  <= '0;
			prev_err_q <= '0;
			integ_q    <= '0;
		end else begin
			if (in_ready) begin
				valid_s2_q <= in_valid;
			end
			if (ld) begin
				hist_q[2]  <= hist_q[1];
				hist_q[1]  <= hist_q[0];
				hist_q[0]  <= in_smp.meas;
				prev_err_q <= err_c;
				integ_q    <= integ_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			err_s2   <= err_c;
			deriv_s2 <= deriv_c;
			integ_s2 <= integ_c;
			dir_s2   <= in_smp.dir;
		end
	end

	assign out_valid = valid_s2_q;
	assign err       = err_s2;
	assign deriv     = deriv_s2;
	assign integ     = integ_s2;
	assign dir       = dir_s2;

`ifndef SYNTHESIS
	a_ld_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ld |=> valid_s2_q)
		else $error("loaded item not valid in error stage");
	a_prev_err: assert property (@(posedge clk) disable iff (!arst_n)
		ld |=> prev_err_q == err_s2)
		else $error("previous error out of step with stage output");
	a_integ: assert property (@(posedge clk) disable iff (!arst_n)
		ld |=> integ_q == integ_s2)
		else $error("integral state out of step with stage output");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ld |=> $stable(integ_q) && $stable(prev_err_q) && $stable(hist_q[0]))
		else $error("loop state changed without a transfer");
`endif

endmodule

// ----- hw/rtl/psla4_mac.sv -----
// Gain stage and output register: three products, sum, scale and duty clamp.
// Depends on psla4_pkg.
module psla4_mac #(
	parameter int unsigned INTEGRAL_WIDTH = 24,
	parameter int unsigned GAIN_FRAC_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [psla4_pkg::ERR_W-1:0]     err,
	input  logic signed [psla4_pkg::DERIV_W-1:0]   deriv,
	input  logic [INTEGRAL_WIDTH-1:0]              integ,
	input  logic                                   dir,
	input  logic [psla4_pkg::GAIN_W-1:0]           kp_gain,
	input  logic [psla4_pkg::GAIN_W-1:0]           ki_gain,
	input  logic [psla4_pkg::GAIN_W-1:0]           kd_gain,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [psla4_pkg::DUTY_W-1:0]           duty,
	output logic                                   drive_direction
);

	localparam int unsigned IW  = INTEGRAL_WIDTH;
	localparam int unsigned GW  = psla4_pkg::GAIN_W;
	localparam int unsigned PEW = GW + psla4_pkg::ERR_W + 1;
	localparam int unsigned PIW = GW + IW;
	localparam int unsigned PDW = GW + psla4_pkg::DERIV_W + 1;
	localparam int unsigned AW  = PIW + 2;
	localparam int unsigned SH  = GAIN_FRAC_BITS + 2;
	localparam int unsigned QW  = AW - SH;

	logic                   valid_s3_q;
	logic signed [PEW-1:0]  pe_s3;
	logic [PIW-1:0]         pi_s3;
	logic signed [PDW-1:0]  pd_s3;
	logic                   dir_s3;

	logic                                out_valid_q;
	logic [psla4_pkg::DUTY_W-1:0]        duty_q;
	logic                                dir_q;

	logic                                out_rdy;
	logic signed [AW-1:0]                acc_c;
	logic [QW-1:0]                       q_c;
	logic [psla4_pkg::DUTY_W-1:0]        duty_c;

	assign out_rdy  = !out_valid_q || out_ready;
	assign in_ready = !valid_s3_q || out_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s3_q <= in_valid;
			end
			if (out_rdy) begin
				out_valid_q <= valid_s3_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pe_s3  <= $signed({1'b0, kp_gain}) * err;
			pi_s3  <= ki_gain * integ;
			pd_s3  <= $signed({1'b0, kd_gain}) * deriv;
			dir_s3 <= dir;
		end
	end

	always_comb begin
		acc_c = $signed({{(AW - PEW){pe_s3[PEW-1]}}, pe_s3})
			+ $signed({2'b00, pi_s3})
			+ $signed({{(AW - PDW){pd_s3[PDW-1]}}, pd_s3});
		q_c = acc_c[AW-1:SH];
		if (acc_c[AW-1]) begin
			duty_c = '0;
		end else if (q_c > {{(QW - psla4_pkg::DUTY_W){1'b0}}, psla4_pkg::DUTY_MAX}) begin
			duty_c = psla4_pkg::DUTY_MAX;
		end else begin
			duty_c = q_c[psla4_pkg::DUTY_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3_q && out_rdy) begin
			duty_q <= duty_c;
			dir_q  <= dir_s3;
		end
	end

	assign out_valid       = out_valid_q;
	assign duty            = duty_q;
	assign drive_direction = dir_q;

endmodule

// ----- hw/rtl/pid_speed_loop_avg4.sv -----
// Top level of the averaged PID speed loop: gain registers and the pipeline.
// Depends on psla4_pkg, psla4_front, psla4_err and psla4_mac.
//
// One input transfer on s_axis is one control tick for one wheel; each tick
// gives exactly one result transfer on m_axis carrying the duty and the
// direction to drive with.
// Gains are written through cfg_we/cfg_addr/cfg_wdata (0 kp, 1 ki, 2 kd);
// the user must write them only while the pipeline is empty, which the block
// does not enforce; other indexes are ignored.
// Pipeline: input register, error/integral stage (holds the loop state),
// product stage, output register. One tick per cycle is sustained while
// m_axis_tready is high; as loop state advances only in the error stage,
// results keep order under any stall pattern. When m_axis_tready is low the
// output register holds its result and the stages behind it keep filling,
// up to four ticks in flight, then s_axis_tready drops.
// Reset clears the speed history, previous error and integral, empties the
// pipeline and loads all three gains with 655 (about 0.01).
module pid_speed_loop_avg4 #(
	parameter int unsigned INTEGRAL_WIDTH = 24,
	parameter int unsigned GAIN_FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [31:0]                        s_axis_tdata,  // cmd_speed[7:0],
	                                                          // measured_speed[23:8],
	                                                          // direction[24]
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [7:0]                         m_axis_tdata,  // duty[6:0],
	                                                          // drive_direction[7]
	input  logic                               cfg_we,
	input  logic [psla4_pkg::CFG_AW-1:0]       cfg_addr,
	input  logic [psla4_pkg::GAIN_W-1:0]       cfg_wdata
);

	logic [psla4_pkg::GAIN_W-1:0]  kp_q;
	logic [psla4_pkg::GAIN_W-1:0]  ki_q;
	logic [psla4_pkg::GAIN_W-1:0]  kd_q;

	logic                                  f_valid;
	logic                                  f_ready;
	psla4_pkg::smp_t                       f_smp;
	logic                                  e_valid;
	logic                                  e_ready;
	logic signed [psla4_pkg::ERR_W-1:0]    e_err;
	logic signed [psla4_pkg::DERIV_W-1:0]  e_deriv;
	logic [INTEGRAL_WIDTH-1:0]             e_integ;
	logic                                  e_dir;
	logic [psla4_pkg::DUTY_W-1:0]          duty;
	logic                                  drive_direction;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= psla4_pkg::GAIN_RESET;
			ki_q <= psla4_pkg::GAIN_RESET;
			kd_q <= psla4_pkg::GAIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				psla4_pkg::CFG_KP: kp_q <= cfg_wdata;
				psla4_pkg::CFG_KI: ki_q <= cfg_wdata;
				psla4_pkg::CFG_KD: kd_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	psla4_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.cmd_speed      (s_axis_tdata[7:0]),
		.measured_speed (s_axis_tdata[23:8]),
		.direction      (s_axis_tdata[24]),
		.out_valid      (f_valid),
		.out_ready      (f_ready),
		.out_smp        (f_smp)
	);

	psla4_err #(
		.INTEGRAL_WIDTH (INTEGRAL_WIDTH)
	) u_err (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_smp    (f_smp),
		.out_valid (e_valid),
		.out_ready (e_ready),
		.err       (e_err),
		.deriv     (e_deriv),
		.integ     (e_integ),
		.dir       (e_dir)
	);

	psla4_mac #(
		.INTEGRAL_WIDTH (INTEGRAL_WIDTH),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_mac (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (e_valid),
		.in_ready        (e_ready),
		.err             (e_err),
		.deriv           (e_deriv),
		.integ           (e_integ),
		.dir             (e_dir),
		.kp_gain         (kp_q),
		.ki_gain         (ki_q),
		.kd_gain         (kd_q),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.duty            (duty),
		.drive_direction (drive_direction)
	);

	assign m_axis_tdata = {drive_direction, duty};

endmodule
